/* hw/rtl/signed_integer_alu_assert.svh */
// Assertion macros for the signed integer ALU.
// Each check is sampled on the rising edge of i_clk and is off while in reset.
`ifndef SIGNED_INTEGER_ALU_ASSERT_SVH
`define SIGNED_INTEGER_ALU_ASSERT_SVH

`ifndef ASSERT_OFF

// Consequent must hold in the same cycle as the antecedent.
`define SIA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("signed_integer_alu: check failed");

// Consequent must hold in the cycle after the antecedent.
`define SIA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("signed_integer_alu: check failed");

`else

`define SIA_ASSERT_NOW(label, ante, cons)
`define SIA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* hw/rtl/sia_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sia_pkg;

    // Datapath width; operands are sign-extended or cut to it
    localparam int WIDTH      = 32;
    // Restoring division steps done in each divider stage
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = (WIDTH + DIV_STEPS - 1) / DIV_STEPS;

    // Stage positions: input register, operand prep, divider stages, output register
    localparam int S_IN   = 0;
    localparam int S_PREP = 1;
    localparam int S_DIV0 = 2;
    localparam int NSTAGE = DIV_STAGES + 3;
    localparam int S_OUT  = NSTAGE - 1;

    typedef logic [WIDTH-1:0] t_word;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    // Payload carried by every pipeline stage
    typedef struct packed {
        t_op   op;
        logic  neg;   // quotient must be negated
        logic  dz;    // divide by zero
        t_word rem;   // partial remainder
        t_word nq;    // dividend bits shifting out, quotient bits shifting in
        t_word dvs;   // divisor magnitude
        t_word res;   // add, subtract or multiply result
    } t_stage;

    // Run DIV_STEPS restoring steps; steps at or past WIDTH leave the stage alone
    function automatic t_stage div_pass(input t_stage st, input int first);
        t_stage       o;
        logic [WIDTH:0] shifted;
        logic [WIDTH:0] diff;
        o = st;
        for (int s = 0; s < DIV_STEPS; s++) begin
            if (first + s < WIDTH) begin
                shifted = {o.rem, o.nq[WIDTH-1]};
                diff    = shifted - {1'b0, o.dvs};
                o.nq    = {o.nq[WIDTH-2:0], ~diff[WIDTH]};
                // keep the difference when it fits, else restore the shifted remainder
                if (!diff[WIDTH]) begin
                    o.rem = diff[WIDTH-1:0];
                end else begin
                    o.rem = shifted[WIDTH-1:0];
                end
            end
        end
        return o;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/signed_integer_alu.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "signed_integer_alu_assert.svh"

// Channel   Dir  tdata (low bit up)              tuser
// s_axis    in   operand_a[31:0], operand_b[63:32] action[1:0]
// m_axis    out  result_value[31:0]              divide_by_zero[0]
//
// One beat enters per cycle when nothing stalls; every result passes through an
// input stage, a prep stage, the divider's eight stages of four restoring steps
// each, and then the output register stage.
// Reset clears only the stage valid bits. A stall at m_axis holds each full
// stage whose successor cannot move; empty stages still fill from s_axis.
module signed_integer_alu
    import sia_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,   // operand_a [31:0], operand_b [63:32]
    input  wire  [1:0]  s_axis_tuser,   // action [1:0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // result_value [31:0]
    output logic [0:0]  m_axis_tuser    // divide_by_zero [0]
);

    logic   [NSTAGE-1:0] r_valid;
    t_stage              r_st [NSTAGE];
    t_stage              n_st [NSTAGE];
    logic   [NSTAGE-1:0] adv;

    // Advance a stage when it is empty or its successor advances
    always_comb begin
        adv[S_OUT] = !r_valid[S_OUT] || m_axis_tready;
        for (int k = S_OUT - 1; k >= 0; k--) begin
            adv[k] = !r_valid[k] || adv[k+1];
        end
    end

    assign s_axis_tready = adv[S_IN];

    // Capture the incoming beat
    always_comb begin
        n_st[S_IN]     = '0;
        n_st[S_IN].op  = t_op'(s_axis_tuser);
        n_st[S_IN].nq  = t_word'($signed(s_axis_tdata[31:0]));
        n_st[S_IN].dvs = t_word'($signed(s_axis_tdata[63:32]));
    end

    // Prep: add, subtract, multiply; magnitudes and signs for divide
    always_comb begin
        t_word a;
        t_word b;
        a = r_st[S_IN].nq;
        b = r_st[S_IN].dvs;
        n_st[S_PREP]     = r_st[S_IN];
        n_st[S_PREP].rem = '0;
        n_st[S_PREP].neg = a[WIDTH-1] ^ b[WIDTH-1];
        n_st[S_PREP].dz  = (r_st[S_IN].op == OP_DIV) && (b == '0);
        n_st[S_PREP].nq  = a[WIDTH-1] ? t_word'(~a + 1'b1) : a;
        n_st[S_PREP].dvs = b[WIDTH-1] ? t_word'(~b + 1'b1) : b;
        case (r_st[S_IN].op)
            OP_ADD:  n_st[S_PREP].res = t_word'(a + b);
            OP_SUB:  n_st[S_PREP].res = t_word'(a - b);
            OP_MUL:  n_st[S_PREP].res = t_word'(a * b);
            default: n_st[S_PREP].res = '0;
        endcase
    end

    // Divider stages, DIV_STEPS quotient bits each
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        always_comb begin
            n_st[S_DIV0+g] = div_pass(r_st[S_DIV0+g-1], g * DIV_STEPS);
        end
    end

    // Select the final result
    always_comb begin
        n_st[S_OUT] = r_st[S_OUT-1];
        if (r_st[S_OUT-1].dz) begin
            n_st[S_OUT].res = '1;
        end else if (r_st[S_OUT-1].op == OP_DIV) begin
            n_st[S_OUT].res = r_st[S_OUT-1].neg ? t_word'(~r_st[S_OUT-1].nq + 1'b1)
                                                : r_st[S_OUT-1].nq;
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (adv[S_IN]) begin
                r_valid[S_IN] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (adv[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTAGE; k++) begin
            if (adv[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign m_axis_tvalid   = r_valid[S_OUT];
    assign m_axis_tdata    = 32'($signed(r_st[S_OUT].res));
    assign m_axis_tuser[0] = r_st[S_OUT].dz;

    // Input back-pressure only when every stage holds a beat
    `SIA_ASSERT_NOW(a_full_when_blocked, !s_axis_tready, &r_valid)
    // Divide by zero returns all ones
    `SIA_ASSERT_NOW(a_dz_all_ones, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '1)
    // Only divides flag a zero divisor
    `SIA_ASSERT_NOW(a_dz_only_div, r_valid[S_OUT] && r_st[S_OUT].op != OP_DIV, !r_st[S_OUT].dz)
    // Restoring division leaves the remainder below the divisor
    `SIA_ASSERT_NOW(a_rem_below_dvs, r_valid[S_OUT-1] && r_st[S_OUT-1].op == OP_DIV && !r_st[S_OUT-1].dz, r_st[S_OUT-1].rem < r_st[S_OUT-1].dvs)
    // A stalled result beat holds its value
    `SIA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import sia_pkg::*;

    localparam int N_DIRECTED     = 25;
    localparam int ITEMS_PER_RUN  = 625;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 4 * NSTAGE;

    localparam logic [31:0] MIN_INT = 32'h8000_0000;
    localparam logic [31:0] MAX_INT = 32'h7fff_ffff;
    localparam logic [31:0] NEG_ONE = 32'hffff_ffff;

    // One ALU answer: the returned value and the divide-by-zero flag
    typedef struct packed {
        logic [31:0] value;
        logic        dz;
    } alu_out_t;

    // One directed operation; typed rows carry their answer, the rest are predicted
    typedef struct {
        t_op         op;
        logic [31:0] a;
        logic [31:0] b;
        bit          typed;
        logic [31:0] value;
        logic        dz;
    } stim_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // operand_a [31:0], operand_b [63:32]
    logic [1:0]  s_axis_tuser;   // action [1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // result_value [31:0]
    logic [0:0]  m_axis_tuser;   // divide_by_zero [0]

    alu_out_t pending_results[$];
    int       mismatch_count;
    int       send_idle_pct;
    int       recv_idle_pct;
    int       holdoff_left;
    int       stall_cycles;

    stim_row_t directed_rows [N_DIRECTED] = '{
        '{OP_ADD, 32'h0,        32'h0,        1'b1, 32'h0,        1'b0},
        '{OP_ADD, MAX_INT,      32'h1,        1'b1, MIN_INT,      1'b0},
        '{OP_ADD, MIN_INT,      NEG_ONE,      1'b1, MAX_INT,      1'b0},
        '{OP_ADD, NEG_ONE,      NEG_ONE,      1'b1, 32'hffff_fffe, 1'b0},
        '{OP_SUB, 32'h0,        MIN_INT,      1'b1, MIN_INT,      1'b0},
        '{OP_SUB, MIN_INT,      32'h1,        1'b1, MAX_INT,      1'b0},
        '{OP_SUB, MAX_INT,      NEG_ONE,      1'b1, MIN_INT,      1'b0},
        '{OP_SUB, 32'h5a5a5a5a, 32'ha5a5a5a5, 1'b0, 32'h0,        1'b0},
        '{OP_MUL, MAX_INT,      MAX_INT,      1'b1, 32'h1,        1'b0},
        '{OP_MUL, MIN_INT,      NEG_ONE,      1'b1, MIN_INT,      1'b0},
        '{OP_MUL, NEG_ONE,      NEG_ONE,      1'b1, 32'h1,        1'b0},
        '{OP_MUL, 32'h12345678, 32'h09abcdef, 1'b0, 32'h0,        1'b0},
        '{OP_DIV, 32'h5,        32'h0,        1'b1, NEG_ONE,      1'b1},
        '{OP_DIV, MIN_INT,      32'h0,        1'b1, NEG_ONE,      1'b1},
        '{OP_DIV, 32'h0,        32'h0,        1'b1, NEG_ONE,      1'b1},
        '{OP_DIV, MIN_INT,      NEG_ONE,      1'b1, MIN_INT,      1'b0},
        '{OP_DIV, 32'h7,        32'hffff_fffe, 1'b1, 32'hffff_fffd, 1'b0},
        '{OP_DIV, 32'hffff_fff9, 32'h2,       1'b1, 32'hffff_fffd, 1'b0},
        '{OP_DIV, 32'hffff_fff9, 32'hffff_fffe, 1'b1, 32'h3,      1'b0},
        '{OP_DIV, MAX_INT,      32'h1,        1'b1, MAX_INT,      1'b0},
        '{OP_DIV, MIN_INT,      32'h1,        1'b1, MIN_INT,      1'b0},
        '{OP_DIV, MIN_INT,      MIN_INT,      1'b1, 32'h1,        1'b0},
        '{OP_DIV, MAX_INT,      MIN_INT,      1'b1, 32'h0,        1'b0},
        '{OP_DIV, 32'h1,        MAX_INT,      1'b1, 32'h0,        1'b0},
        '{OP_DIV, 32'hdeadbeef, 32'h3039,     1'b0, 32'h0,        1'b0}
    };

    signed_integer_alu u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 2 ns clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Compute the ALU answer at the datapath width, then widen to 32 bits
    function automatic alu_out_t alu_result(input t_op op, input logic [31:0] a,
                                            input logic [31:0] b);
        longint   ax;
        longint   bx;
        longint   rx;
        t_word    wa;
        t_word    wb;
        t_word    ma;
        t_word    mb;
        t_word    r;
        alu_out_t o;
        ax   = $signed(a);
        bx   = $signed(b);
        wa   = ax[WIDTH-1:0];
        wb   = bx[WIDTH-1:0];
        o.dz = 1'b0;
        case (op)
            OP_ADD: r = wa + wb;
            OP_SUB: r = wa - wb;
            OP_MUL: r = wa * wb;
            default: begin
                if (wb == '0) begin
                    r    = '1;
                    o.dz = 1'b1;
                end else begin
                    // divide magnitudes, then fix the sign so it truncates toward zero
                    ma = wa[WIDTH-1] ? -wa : wa;
                    mb = wb[WIDTH-1] ? -wb : wb;
                    r  = ma / mb;
                    if (wa[WIDTH-1] != wb[WIDTH-1]) begin
                        r = -r;
                    end
                end
            end
        endcase
        rx      = $signed(r);
        o.value = rx[31:0];
        return o;
    endfunction

    // Full-range values most often, with corners, small numbers and short magnitudes mixed in
    function automatic logic [31:0] rand_operand();
        logic [31:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = $urandom;
            4: begin
                case ($urandom_range(4))
                    0: v = 32'h0;
                    1: v = 32'h1;
                    2: v = NEG_ONE;
                    3: v = MIN_INT;
                    default: v = MAX_INT;
                endcase
            end
            5, 6: v = 32'($urandom_range(200)) - 32'd100;
            default: begin
                v = $urandom >> $urandom_range(31);
                if ($urandom_range(1) == 1) begin
                    v = -v;
                end
            end
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] %s: got %h, want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Present one beat from a falling edge and hold it until taken; idle first at random
    task automatic offer(input t_op op, input logic [31:0] a, input logic [31:0] b,
                         input alu_out_t want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {$urandom, $urandom};
            s_axis_tuser  <= 2'($urandom_range(3));
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tuser  <= op;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        pending_results.push_back(want);
        @(negedge i_clk);
    endtask

    // Drop valid and hold until every outstanding result has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic run_random(input int count, input bit with_holdoff);
        t_op         op;
        logic [31:0] a;
        logic [31:0] b;
        for (int i = 0; i < count; i++) begin
            // long receiver stall partway in, while beats keep coming
            if (with_holdoff && i == count / 3) begin
                holdoff_left = HOLDOFF_CYCLES;
            end
            op = t_op'($urandom_range(3));
            a  = rand_operand();
            b  = rand_operand();
            if (op == OP_DIV && $urandom_range(24) == 0) begin
                b = 32'h0;
            end
            offer(op, a, b, alu_result(op, a, b));
        end
    endtask

    // Drive tready at falling edges: a requested hold-off first, else random idling
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holdoff_left > 0) begin
                m_axis_tready <= 1'b0;
                holdoff_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Compare each result beat with the oldest outstanding answer
    always @(posedge i_clk) begin
        alu_out_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result beat", m_axis_tdata, 32'h0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata !== want.value) begin
                    report_mismatch("result_value", m_axis_tdata, want.value);
                end
                if (m_axis_tuser[0] !== want.dz) begin
                    report_mismatch("divide_by_zero", 32'(m_axis_tuser), 32'(want.dz));
                end
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("signed_integer_alu: mismatch");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        stim_row_t row;
        alu_out_t  want;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = OP_ADD;
        mismatch_count = 0;
        holdoff_left   = 0;
        stall_cycles   = 0;
        send_idle_pct  = 31;
        recv_idle_pct  = 58;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed corners, then random beats with a slow receiver
        for (int i = 0; i < N_DIRECTED; i++) begin
            row  = directed_rows[i];
            want = row.typed ? alu_out_t'{row.value, row.dz}
                             : alu_result(row.op, row.a, row.b);
            offer(row.op, row.a, row.b, want);
        end
        run_random(ITEMS_PER_RUN, 1'b0);
        wait_drained();

        // slow sender, fast receiver
        send_idle_pct = 58;
        recv_idle_pct = 31;
        run_random(ITEMS_PER_RUN, 1'b0);
        wait_drained();

        // full rate both sides, with one long receiver stall
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(ITEMS_PER_RUN, 1'b1);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("signed_integer_alu: match");
        end else begin
            $display("signed_integer_alu: mismatch");
        end
        $finish;
    end

endmodule
